// ===== rtl/kml_pkg.sv =====
package kml_pkg;

	// Sizes fixed by the port fields
	localparam int MAX_POINTS_DEF = 1024;
	localparam int MAX_CLUSTERS = 16;
	localparam int FEATURES_MAX = 8;
	localparam int FEATURE_BITS = 16;
	localparam int CENT_BITS = 24;
	localparam int IDX_W = 10;
	localparam int CL_W = 4;
	localparam int KC_W = 5;
	localparam int FC_W = 4;
	localparam int F_W = 3;
	localparam int RC_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	// Distance arithmetic: point*256 - centroid, squared, summed over features
	localparam int DIFF_W = FEATURE_BITS + 9;
	localparam int SQ_W = 2 * DIFF_W - 1;
	localparam int DIST_W = SQ_W + F_W;

	// Item kinds
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_RD_PT = 2'd1;
	localparam logic [1:0] KIND_RD_CT = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEATURES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [IDX_W-1:0] item_index;
		logic last_point;
		logic signed [FEATURE_BITS-1:0] feat0;
		logic signed [FEATURE_BITS-1:0] feat1;
		logic signed [FEATURE_BITS-1:0] feat2;
		logic signed [FEATURE_BITS-1:0] feat3;
		logic signed [FEATURE_BITS-1:0] feat4;
		logic signed [FEATURE_BITS-1:0] feat5;
		logic signed [FEATURE_BITS-1:0] feat6;
		logic signed [FEATURE_BITS-1:0] feat7;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] echo_index;
		logic [CL_W-1:0] assigned_cluster;
		logic [1:0] status;
		logic signed [CENT_BITS-1:0] cent0;
		logic signed [CENT_BITS-1:0] cent1;
		logic signed [CENT_BITS-1:0] cent2;
		logic signed [CENT_BITS-1:0] cent3;
		logic signed [CENT_BITS-1:0] cent4;
		logic signed [CENT_BITS-1:0] cent5;
		logic signed [CENT_BITS-1:0] cent6;
		logic signed [CENT_BITS-1:0] cent7;
	} result_t;

	// Result source select
	typedef enum logic [1:0] {OSEL_LOAD, OSEL_PT, OSEL_CT} osel_t;

	// Controller to datapath
	typedef struct packed {
		logic in_ld;
		logic div_mod;
		logic div_mean;
		logic ld_wr;
		logic pt_rd;
		logic ct_rd;
		logic from_item;
		logic acc_clr;
		logic acc_en;
		logic row_ld;
		logic row_upd;
		logic ct_wr;
		logic sq_en;
		logic dist_clr;
		logic best_upd;
		logic asg_wr;
		logic out_ld;
		osel_t osel;
		logic [CL_W-1:0] j;
		logic [F_W-1:0] f;
		logic [KC_W-1:0] k;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic last;
		logic div_done;
		logic has_members;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/kml_div.sv =====
// Restoring divider, one quotient bit per cycle
module kml_div #(
	parameter int DVD_W = 36,
	parameter int DVS_W = 11
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DVD_W-1:0] dividend,
	input logic [DVS_W-1:0] divisor,
	output logic done,
	output logic [DVD_W-1:0] quo,
	output logic [DVS_W-1:0] rem
);

	localparam int ITER_W = $clog2(DVD_W + 1);

	logic busy_q;
	logic done_q;
	logic [ITER_W-1:0] iter_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0] trial;
	logic [DVS_W:0] trial_sub;
	logic ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(DVD_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign rem = rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");

endmodule

// ===== rtl/kml_dp.sv =====
// Point and centroid stores, accumulators, divider, distance unit, result word
module kml_dp #(
	parameter int MAX_POINTS = kml_pkg::MAX_POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input kml_pkg::item_t item,
	input kml_pkg::cmd_t cmd,
	input logic [$clog2(MAX_POINTS+1)-1:0] point_idx,
	input logic [$clog2(MAX_POINTS+1)-1:0] pts_loaded,
	output kml_pkg::sts_t sts,
	output logic result_valid,
	input logic result_ready,
	output kml_pkg::result_t result
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SUM_W = kml_pkg::FEATURE_BITS + CNT_W;
	localparam int DVD_W = SUM_W + 9;
	localparam int DVS_W = (CNT_W > kml_pkg::KC_W) ? CNT_W : kml_pkg::KC_W;
	localparam int CMP_W = (CNT_W > kml_pkg::IDX_W) ? CNT_W : kml_pkg::IDX_W;
	localparam int FB = kml_pkg::FEATURE_BITS;
	localparam int CB = kml_pkg::CENT_BITS;
	localparam int NF = kml_pkg::FEATURES_MAX;
	localparam int PT_W = NF * FB;
	localparam int ROW_W = NF * CB;
	localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(1) << (CB - 1);
	localparam logic [DVD_W-1:0] POS_LIM = NEG_LIM - DVD_W'(1);

	kml_pkg::item_t in_q;

	logic [PT_W-1:0] pt_mem [MAX_POINTS];
	logic [kml_pkg::CL_W-1:0] cl_mem [MAX_POINTS];
	logic [ROW_W-1:0] ct_mem [kml_pkg::MAX_CLUSTERS];
	logic [kml_pkg::MAX_CLUSTERS-1:0] ct_vld_q;

	logic [PT_W-1:0] pt_rd_q;
	logic [kml_pkg::CL_W-1:0] cl_rd_q;
	logic [ROW_W-1:0] ct_raw_q;
	logic ct_hit_q;
	logic [ROW_W-1:0] ct_rd_data;
	logic [ROW_W-1:0] row_q;

	logic [AW-1:0] pt_raddr;
	logic [AW-1:0] pl_addr;
	logic [kml_pkg::CL_W-1:0] ct_raddr;
	logic full;

	logic acc_s1;
	logic signed [SUM_W-1:0] sum_q [NF];
	logic [CNT_W-1:0] cnt_q;

	logic signed [SUM_W-1:0] sum_sel;
	logic sum_neg;
	logic [SUM_W-1:0] mag;
	logic div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic div_done;
	logic [DVD_W-1:0] div_quo;
	logic [DVS_W-1:0] div_rem;
	logic [CB-1:0] mean_val;

	logic signed [FB-1:0] p_f;
	logic signed [CB-1:0] c_f;
	logic signed [kml_pkg::DIFF_W-1:0] diff;
	logic signed [2*kml_pkg::DIFF_W-1:0] prod;
	logic [kml_pkg::SQ_W-1:0] sq_s1;
	logic sq_v_s1;
	logic [kml_pkg::DIST_W-1:0] dist_q;
	logic [kml_pkg::DIST_W-1:0] best_d_q;
	logic [kml_pkg::CL_W-1:0] best_q;

	logic result_valid_q;
	kml_pkg::result_t result_q;
	kml_pkg::result_t res_next;
	logic pt_ok;
	logic ct_ok;

	// input word latch
	always_ff @(posedge clk) begin
		if (cmd.in_ld) begin
			in_q <= item;
		end
	end

	assign full = pts_loaded >= CNT_W'(MAX_POINTS);
	assign pl_addr = pts_loaded[AW-1:0];
	assign pt_raddr = cmd.from_item ? AW'(in_q.item_index) : point_idx[AW-1:0];
	assign ct_raddr = cmd.from_item ? in_q.item_index[kml_pkg::CL_W-1:0] : cmd.j;

	// point store and cluster store
	always_ff @(posedge clk) begin
		if (cmd.ld_wr && !full) begin
			pt_mem[pl_addr] <= {in_q.feat7, in_q.feat6, in_q.feat5, in_q.feat4,
				in_q.feat3, in_q.feat2, in_q.feat1, in_q.feat0};
		end
		if (cmd.pt_rd) begin
			pt_rd_q <= pt_mem[pt_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_wr && !full) begin
			cl_mem[pl_addr] <= div_rem[kml_pkg::CL_W-1:0];
		end else if (cmd.asg_wr) begin
			cl_mem[point_idx[AW-1:0]] <= best_q;
		end
		if (cmd.pt_rd) begin
			cl_rd_q <= cl_mem[pt_raddr];
		end
	end

	// centroid store; a row never written reads as zero
	always_ff @(posedge clk) begin
		if (cmd.ct_wr) begin
			ct_mem[cmd.j] <= row_q;
		end
		if (cmd.ct_rd) begin
			ct_raw_q <= ct_mem[ct_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct_vld_q <= '0;
			ct_hit_q <= 1'b0;
		end else begin
			if (cmd.ct_wr) begin
				ct_vld_q[cmd.j] <= 1'b1;
			end
			if (cmd.ct_rd) begin
				ct_hit_q <= ct_vld_q[ct_raddr];
			end
		end
	end

	assign ct_rd_data = ct_hit_q ? ct_raw_q : '0;

	// per-cluster sums and member count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
		end else begin
			acc_s1 <= cmd.acc_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			for (int n = 0; n < NF; n++) begin
				sum_q[n] <= '0;
			end
			cnt_q <= '0;
		end else if (acc_s1 && cl_rd_q == cmd.j) begin
			for (int n = 0; n < NF; n++) begin
				sum_q[n] <= sum_q[n] + SUM_W'($signed(pt_rd_q[n*FB +: FB]));
			end
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// divider operands: slot mod clusters, or rounded mean of one feature
	assign sum_sel = sum_q[cmd.f];
	assign sum_neg = sum_sel[SUM_W-1];
	assign mag = sum_neg ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
	assign div_start = cmd.div_mod | cmd.div_mean;

	always_comb begin
		if (cmd.div_mod) begin
			div_dvd = DVD_W'(pts_loaded);
			div_dvs = DVS_W'(cmd.k);
		end else begin
			div_dvd = DVD_W'({mag, 8'h00}) + DVD_W'(cnt_q >> 1);
			div_dvs = DVS_W'(cnt_q);
		end
	end

	kml_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.done(div_done),
		.quo(div_quo),
		.rem(div_rem)
	);

	// saturate the magnitude, then apply the sign
	always_comb begin
		if (sum_neg) begin
			mean_val = (div_quo >= NEG_LIM) ? NEG_LIM[CB-1:0] : CB'(-div_quo);
		end else begin
			mean_val = (div_quo > POS_LIM) ? POS_LIM[CB-1:0] : div_quo[CB-1:0];
		end
	end

	// new centroid row
	always_ff @(posedge clk) begin
		if (cmd.row_ld) begin
			row_q <= ct_rd_data;
		end else if (cmd.row_upd) begin
			row_q[cmd.f*CB +: CB] <= mean_val;
		end
	end

	// one feature per cycle: square registered, then summed
	assign p_f = $signed(pt_rd_q[cmd.f*FB +: FB]);
	assign c_f = $signed(ct_rd_data[cmd.f*CB +: CB]);
	assign diff = kml_pkg::DIFF_W'($signed({p_f, 8'h00})) - kml_pkg::DIFF_W'(c_f);
	assign prod = diff * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s1 <= 1'b0;
		end else begin
			sq_v_s1 <= cmd.sq_en;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= prod[kml_pkg::SQ_W-1:0];
		if (cmd.dist_clr) begin
			dist_q <= '0;
		end else if (sq_v_s1) begin
			dist_q <= dist_q + kml_pkg::DIST_W'(sq_s1);
		end
		// lowest distance so far; ties keep the lower cluster
		if (cmd.best_upd && (cmd.j == '0 || dist_q < best_d_q)) begin
			best_d_q <= dist_q;
			best_q <= cmd.j;
		end
	end

	// result word
	assign pt_ok = CMP_W'(in_q.item_index) < CMP_W'(pts_loaded);
	assign ct_ok = in_q.item_index < kml_pkg::IDX_W'(cmd.k);

	always_comb begin
		res_next = '0;
		unique case (cmd.osel)
			kml_pkg::OSEL_LOAD: begin
				res_next.echo_index = full ? '0 : kml_pkg::IDX_W'(pts_loaded);
				res_next.status = full ? kml_pkg::ST_FULL : kml_pkg::ST_OK;
			end
			kml_pkg::OSEL_PT: begin
				res_next.echo_index = in_q.item_index;
				res_next.status = pt_ok ? kml_pkg::ST_OK : kml_pkg::ST_RANGE;
				res_next.assigned_cluster = pt_ok ? cl_rd_q : '0;
			end
			default: begin
				res_next.echo_index = in_q.item_index;
				res_next.status = ct_ok ? kml_pkg::ST_OK : kml_pkg::ST_RANGE;
				if (ct_ok) begin
					res_next.cent0 = ct_rd_data[0*CB +: CB];
					res_next.cent1 = ct_rd_data[1*CB +: CB];
					res_next.cent2 = ct_rd_data[2*CB +: CB];
					res_next.cent3 = ct_rd_data[3*CB +: CB];
					res_next.cent4 = ct_rd_data[4*CB +: CB];
					res_next.cent5 = ct_rd_data[5*CB +: CB];
					res_next.cent6 = ct_rd_data[6*CB +: CB];
					res_next.cent7 = ct_rd_data[7*CB +: CB];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	assign sts.kind = in_q.kind;
	assign sts.last = in_q.last_point;
	assign sts.div_done = div_done;
	assign sts.has_members = cnt_q != '0;
	assign sts.out_busy = result_valid_q & ~result_ready;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !(result_valid_q && !result_ready))
		else $error("result word overwritten before it was taken");

endmodule

// ===== rtl/kml_ctrl.sv =====
// Sequencer: item decode, load, reads, and the update and assignment sweeps
module kml_ctrl #(
	parameter int MAX_POINTS = kml_pkg::MAX_POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input logic cfg_valid,
	input logic [kml_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [kml_pkg::CFG_DATA_W-1:0] cfg_data,
	input kml_pkg::sts_t sts,
	output kml_pkg::cmd_t cmd,
	output logic [$clog2(MAX_POINTS+1)-1:0] point_idx,
	output logic [$clog2(MAX_POINTS+1)-1:0] pts_loaded
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_LD_WAIT, S_LD_WR, S_RD_OUT,
		S_UPD_START, S_UPD_SWEEP, S_UPD_DRAIN, S_UPD_CHK, S_UPD_ROW,
		S_UPD_DIV, S_UPD_WAIT, S_UPD_WR,
		S_ASG_PT, S_ASG_CT, S_ASG_DIST, S_ASG_SUM, S_ASG_CMP, S_ASG_WR,
		S_RND_END
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] pl_q;
	logic [kml_pkg::CL_W-1:0] j_q;
	logic [kml_pkg::F_W-1:0] f_q;
	logic [kml_pkg::RC_W-1:0] r_q;
	logic [kml_pkg::KC_W-1:0] cc_q;
	logic [kml_pkg::FC_W-1:0] fc_q;
	logic [kml_pkg::RC_W-1:0] rc_q;

	logic [kml_pkg::KC_W-1:0] k_eff;
	logic [kml_pkg::FC_W-1:0] nf_eff;
	logic full;
	logic last_i;
	logic last_j;
	logic last_f;
	logic last_r;
	logic is_read;

	// clamp the registers to their working ranges
	assign k_eff = (cc_q == '0) ? kml_pkg::KC_W'(1) :
		(cc_q > kml_pkg::KC_W'(kml_pkg::MAX_CLUSTERS)) ?
		kml_pkg::KC_W'(kml_pkg::MAX_CLUSTERS) : cc_q;
	assign nf_eff = (fc_q == '0) ? kml_pkg::FC_W'(1) :
		(fc_q > kml_pkg::FC_W'(kml_pkg::FEATURES_MAX)) ?
		kml_pkg::FC_W'(kml_pkg::FEATURES_MAX) : fc_q;

	assign full = pl_q >= CNT_W'(MAX_POINTS);
	assign last_i = i_q == pl_q - CNT_W'(1);
	assign last_j = {1'b0, j_q} == k_eff - kml_pkg::KC_W'(1);
	assign last_f = {1'b0, f_q} == nf_eff - kml_pkg::FC_W'(1);
	assign last_r = r_q == rc_q - kml_pkg::RC_W'(1);
	assign is_read = sts.kind == kml_pkg::KIND_RD_PT || sts.kind == kml_pkg::KIND_RD_CT;

	// state, loop counters and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			pl_q <= '0;
			j_q <= '0;
			f_q <= '0;
			r_q <= '0;
			cc_q <= kml_pkg::KC_W'(2);
			fc_q <= kml_pkg::FC_W'(8);
			rc_q <= kml_pkg::RC_W'(10);
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					kml_pkg::REG_CLUSTERS: cc_q <= cfg_data[kml_pkg::KC_W-1:0];
					kml_pkg::REG_FEATURES: fc_q <= cfg_data[kml_pkg::FC_W-1:0];
					kml_pkg::REG_ROUNDS: rc_q <= cfg_data[kml_pkg::RC_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (sts.kind == kml_pkg::KIND_LOAD) begin
						state_q <= full ? S_LD_WR : S_LD_WAIT;
					end else if (is_read) begin
						state_q <= S_RD_OUT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_LD_WAIT: begin
					if (sts.div_done) begin
						state_q <= S_LD_WR;
					end
				end
				S_LD_WR: begin
					if (!sts.out_busy) begin
						if (!full) begin
							pl_q <= pl_q + CNT_W'(1);
						end
						r_q <= '0;
						j_q <= '0;
						state_q <= (sts.last && rc_q != '0) ? S_UPD_START : S_IDLE;
					end
				end
				S_RD_OUT: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				// update: sum the members of cluster j, then divide per feature
				S_UPD_START: begin
					i_q <= '0;
					state_q <= (pl_q == '0) ? S_UPD_DRAIN : S_UPD_SWEEP;
				end
				S_UPD_SWEEP: begin
					if (last_i) begin
						state_q <= S_UPD_DRAIN;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				S_UPD_DRAIN: state_q <= S_UPD_CHK;
				S_UPD_CHK: begin
					f_q <= '0;
					if (sts.has_members) begin
						state_q <= S_UPD_ROW;
					end else if (last_j) begin
						i_q <= '0;
						state_q <= (pl_q == '0) ? S_RND_END : S_ASG_PT;
					end else begin
						j_q <= j_q + kml_pkg::CL_W'(1);
						state_q <= S_UPD_START;
					end
				end
				S_UPD_ROW: state_q <= S_UPD_DIV;
				S_UPD_DIV: state_q <= S_UPD_WAIT;
				S_UPD_WAIT: begin
					if (sts.div_done) begin
						if (last_f) begin
							state_q <= S_UPD_WR;
						end else begin
							f_q <= f_q + kml_pkg::F_W'(1);
							state_q <= S_UPD_DIV;
						end
					end
				end
				S_UPD_WR: begin
					if (last_j) begin
						i_q <= '0;
						state_q <= (pl_q == '0) ? S_RND_END : S_ASG_PT;
					end else begin
						j_q <= j_q + kml_pkg::CL_W'(1);
						state_q <= S_UPD_START;
					end
				end
				// assignment: nearest centroid for point i
				S_ASG_PT: begin
					j_q <= '0;
					state_q <= S_ASG_CT;
				end
				S_ASG_CT: begin
					f_q <= '0;
					state_q <= S_ASG_DIST;
				end
				S_ASG_DIST: begin
					if (last_f) begin
						state_q <= S_ASG_SUM;
					end else begin
						f_q <= f_q + kml_pkg::F_W'(1);
					end
				end
				S_ASG_SUM: state_q <= S_ASG_CMP;
				S_ASG_CMP: begin
					if (last_j) begin
						state_q <= S_ASG_WR;
					end else begin
						j_q <= j_q + kml_pkg::CL_W'(1);
						state_q <= S_ASG_CT;
					end
				end
				S_ASG_WR: begin
					if (last_i) begin
						state_q <= S_RND_END;
					end else begin
						i_q <= i_q + CNT_W'(1);
						state_q <= S_ASG_PT;
					end
				end
				S_RND_END: begin
					j_q <= '0;
					if (last_r) begin
						state_q <= S_IDLE;
					end else begin
						r_q <= r_q + kml_pkg::RC_W'(1);
						state_q <= S_UPD_START;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		cmd.j = j_q;
		cmd.f = f_q;
		cmd.k = k_eff;
		cmd.osel = kml_pkg::OSEL_LOAD;
		unique case (state_q)
			S_IDLE: cmd.in_ld = 1'b1;
			S_DECODE: begin
				cmd.div_mod = sts.kind == kml_pkg::KIND_LOAD && !full;
				cmd.from_item = 1'b1;
				cmd.pt_rd = is_read;
				cmd.ct_rd = is_read;
			end
			S_LD_WR: begin
				cmd.ld_wr = !sts.out_busy;
				cmd.out_ld = !sts.out_busy;
			end
			S_RD_OUT: begin
				cmd.out_ld = !sts.out_busy;
				cmd.osel = (sts.kind == kml_pkg::KIND_RD_PT) ?
					kml_pkg::OSEL_PT : kml_pkg::OSEL_CT;
			end
			S_UPD_START: cmd.acc_clr = 1'b1;
			S_UPD_SWEEP: begin
				cmd.pt_rd = 1'b1;
				cmd.acc_en = 1'b1;
			end
			S_UPD_CHK: cmd.ct_rd = sts.has_members;
			S_UPD_ROW: cmd.row_ld = 1'b1;
			S_UPD_DIV: cmd.div_mean = 1'b1;
			S_UPD_WAIT: cmd.row_upd = sts.div_done;
			S_UPD_WR: cmd.ct_wr = 1'b1;
			S_ASG_PT: cmd.pt_rd = 1'b1;
			S_ASG_CT: begin
				cmd.ct_rd = 1'b1;
				cmd.dist_clr = 1'b1;
			end
			S_ASG_DIST: cmd.sq_en = 1'b1;
			S_ASG_CMP: cmd.best_upd = 1'b1;
			S_ASG_WR: cmd.asg_wr = 1'b1;
			default: ;
		endcase
	end

	assign item_ready = state_q == S_IDLE;
	assign point_idx = i_q;
	assign pts_loaded = pl_q;

	a_pl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pl_q <= CNT_W'(MAX_POINTS)) else $error("point count beyond store size");
	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD_SWEEP || state_q == S_ASG_WR) |-> i_q < pl_q)
		else $error("point sweep beyond loaded points");

endmodule

// ===== rtl/kmeans_lloyd_clustering.sv =====
// k-means clustering by Lloyd rounds. Load words store one point each and put
// it in cluster (slot mod cluster_count); a load with last_point set then runs
// round_count rounds over all stored points, each a centroid update (rounded
// Q16.8 mean, empty clusters keep their centroid) and a nearest-centroid
// assignment. Words are taken one at a time; a load waits on the bit-serial
// divider that forms the slot modulo. A round is paced by the single
// point-store read port, the one shared divider and the one squared-difference
// multiplier. The result word is registered and can wait on result_ready while
// the next word is taken in.
module kmeans_lloyd_clustering #(
	parameter int MAX_POINTS = kml_pkg::MAX_POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input kml_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output kml_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [kml_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [kml_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	kml_pkg::cmd_t cmd;
	kml_pkg::sts_t sts;
	logic [CNT_W-1:0] point_idx;
	logic [CNT_W-1:0] pts_loaded;

	// registers are always writable
	assign cfg_ready = 1'b1;

	kml_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sts(sts),
		.cmd(cmd),
		.point_idx(point_idx),
		.pts_loaded(pts_loaded)
	);

	kml_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.point_idx(point_idx),
		.pts_loaded(pts_loaded),
		.sts(sts),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule
